// ===== rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Request and response payload types, request codes and character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  // One request as it arrives on the request channel.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  char_code;
    logic [7:0]  color_value;
    logic [10:0] cell_index;
  } req_t;

  // One response: cursor after the request, the cell read and the scroll flag.
  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [15:0] cell_data;
    logic        scrolled;
  } rsp_t;

  // Request codes.
  localparam logic [2:0] REQ_PUT_CHAR  = 3'd0;
  localparam logic [2:0] REQ_BACKSPACE = 3'd1;
  localparam logic [2:0] REQ_CLEAR     = 3'd2;
  localparam logic [2:0] REQ_SET_COLOR = 3'd3;
  localparam logic [2:0] REQ_READ_CELL = 3'd4;

  // Character and attribute constants.
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_BLANK   = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR = 8'h0F;

endpackage

`default_nettype wire

// ===== rtl/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character screen with cursor, scrolling, backspace, clear and cell readback.
// ----------------------------------------------------------------------------
// The engine takes one request at a time; req_ready is high only while the
// sequencer is idle. Set color, unknown codes, newline, tab, backspace and
// ordinary characters go straight from the execute state to the done state;
// a read cell with an in-range index passes through an extra read state
// because of the registered memory read. A clear, or any request that moves
// the cursor past the bottom row, walks the whole screen memory through its
// single write port. After reset the same walk blanks the memory before the
// first request is taken. A finished response waits in the output register;
// the next request may be taken while it is still pending.
`default_nettype none

module text_console_cursor_engine #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int TAB_STEP    = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tcce_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tcce_pkg::rsp_t rsp
);

  import tcce_pkg::*;

  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
  localparam int COPY_COUNT = SCREEN_COLS * (SCREEN_ROWS - 1);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(SCREEN_COLS);
  localparam int ROW_W      = $clog2(SCREEN_ROWS);
  localparam int PH_W       = $clog2(TAB_STEP);
  localparam int TCOL_W     = COL_W + PH_W + 1;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DONE
  } state_t;

  state_t            state;
  req_t              req_q;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [PH_W-1:0]   phase;
  logic [7:0]        attr;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] sweep_idx;
  logic              sweep_scroll;
  logic              sweep_reply;
  logic [15:0]       pend_data;
  logic              pend_scrolled;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  logic [COL_W:0]    col_inc;
  logic [TCOL_W-1:0] tab_col;
  logic              at_bottom;
  logic              idx_ok;
  logic [ROW_W-1:0]  ex_row;
  logic [COL_W-1:0]  ex_col;
  logic [PH_W-1:0]   ex_phase;
  logic              ex_newline;
  logic              ex_scroll;
  logic              ex_we;
  logic [ADDR_W-1:0] ex_waddr;
  logic [15:0]       ex_wdata;

  assign req_ready = (state == S_IDLE);

  // Shared cursor arithmetic.
  assign col_inc   = {1'b0, col} + 1'b1;
  assign tab_col   = TCOL_W'(col) + TCOL_W'(TAB_STEP) - TCOL_W'(phase);
  assign at_bottom = (row == ROW_W'(SCREEN_ROWS - 1));
  assign idx_ok    = (32'(req_q.cell_index) < CELL_COUNT);

  // Cursor movement and cell write for put char and backspace.
  always_comb begin
    ex_row     = row;
    ex_col     = col;
    ex_phase   = phase;
    ex_newline = 1'b0;
    ex_scroll  = 1'b0;
    ex_we      = 1'b0;
    ex_waddr   = base_addr;
    ex_wdata   = {attr, req_q.char_code};
    case (req_q.req_type)
      REQ_PUT_CHAR: begin
        if (req_q.char_code == CHAR_NEWLINE) begin
          ex_newline = 1'b1;
        end else if (req_q.char_code == CHAR_TAB) begin
          if (32'(tab_col) >= SCREEN_COLS) begin
            ex_newline = 1'b1;
          end else begin
            ex_col   = COL_W'(tab_col);
            ex_phase = '0;
          end
        end else begin
          ex_we = 1'b1;
          if (32'(col_inc) >= SCREEN_COLS) begin
            ex_newline = 1'b1;
          end else begin
            ex_col   = COL_W'(col_inc);
            ex_phase = (phase == PH_W'(TAB_STEP - 1)) ? '0 : phase + 1'b1;
          end
        end
      end
      REQ_BACKSPACE: begin
        if (col != '0) begin
          ex_we    = 1'b1;
          ex_waddr = base_addr - 1'b1;
          ex_wdata = {attr, CHAR_BLANK};
          ex_col   = col - 1'b1;
          ex_phase = (phase == '0) ? PH_W'(TAB_STEP - 1) : phase - 1'b1;
        end
      end
      default: begin
      end
    endcase
    // A row advance past the bottom leaves the cursor on the last row.
    if (ex_newline) begin
      ex_col    = '0;
      ex_phase  = '0;
      ex_row    = at_bottom ? row : row + 1'b1;
      ex_scroll = at_bottom;
    end
  end

  // Memory port selection by sequencer state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ex_waddr;
    ram_wdata = ex_wdata;
    ram_raddr = ADDR_W'(req_q.cell_index);
    unique case (state)
      S_SWEEP: begin
        // Copy one cell up a row, or blank it; prefetch the next source.
        ram_we    = 1'b1;
        ram_waddr = sweep_idx;
        ram_wdata = (sweep_scroll && (sweep_idx < ADDR_W'(COPY_COUNT))) ?
                    ram_rdata : {attr, CHAR_BLANK};
        ram_raddr = ADDR_W'({1'b0, sweep_idx} + (ADDR_W + 1)'(SCREEN_COLS + 1));
      end
      S_EXEC: begin
        ram_we = ex_we;
        if (ex_scroll) begin
          ram_raddr = ADDR_W'(SCREEN_COLS);
        end
      end
      default: begin
      end
    endcase
  end

  tcce_screen_ram #(
    .DEPTH (CELL_COUNT),
    .ADDR_W(ADDR_W)
  ) u_screen_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer, cursor state and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep_idx    <= '0;
      sweep_scroll <= 1'b0;
      sweep_reply  <= 1'b0;
      row          <= '0;
      col          <= '0;
      phase        <= '0;
      attr         <= DEFAULT_ATTR;
      rsp_valid    <= 1'b0;
    end else begin
      // A response leaving while a new one is loaded stays valid.
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          if (sweep_idx == ADDR_W'(CELL_COUNT - 1)) begin
            sweep_idx <= '0;
            state     <= sweep_reply ? S_DONE : S_IDLE;
          end else begin
            sweep_idx <= sweep_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            req_q         <= req;
            base_addr     <= ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_COLS)) + ADDR_W'(col);
            pend_data     <= '0;
            pend_scrolled <= 1'b0;
            state         <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (req_q.req_type)
            REQ_CLEAR: begin
              row          <= '0;
              col          <= '0;
              phase        <= '0;
              attr         <= DEFAULT_ATTR;
              sweep_idx    <= '0;
              sweep_scroll <= 1'b0;
              sweep_reply  <= 1'b1;
              state        <= S_SWEEP;
            end
            REQ_SET_COLOR: begin
              attr  <= req_q.color_value;
              state <= S_DONE;
            end
            REQ_READ_CELL: begin
              state <= idx_ok ? S_READ : S_DONE;
            end
            default: begin
              row   <= ex_row;
              col   <= ex_col;
              phase <= ex_phase;
              if (ex_scroll) begin
                pend_scrolled <= 1'b1;
                sweep_idx     <= '0;
                sweep_scroll  <= 1'b1;
                sweep_reply   <= 1'b1;
                state         <= S_SWEEP;
              end else begin
                state <= S_DONE;
              end
            end
          endcase
        end
        S_READ: begin
          pend_data <= ram_rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.cursor_row <= 5'(row);
            rsp.cursor_col <= 7'(col);
            rsp.cell_data  <= pend_data;
            rsp.scrolled   <= pend_scrolled;
            rsp_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The cursor never leaves the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    (32'(row) < SCREEN_ROWS) && (32'(col) < SCREEN_COLS))
    else $error("cursor outside the screen");

  // The memory is only written while a request or sweep is in progress.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("screen write while idle");

  // A scrolled response always reports the bottom row.
  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.scrolled) |-> (rsp.cursor_row == 5'(SCREEN_ROWS - 1)))
    else $error("scrolled response not on the bottom row");
`endif

endmodule

`default_nettype wire

// ===== rtl/tcce_screen_ram.sv =====
// ----------------------------------------------------------------------------
// Screen cell memory
// One write port and one read port with registered read data, 16-bit cells.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [15:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== tb/text_console_checker.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine checker
// Watches both channels and keeps its own copy of the screen, cursor and
// attribute. Each request transfer is run through that copy to get the
// expected response. Each response transfer is compared field by field with
// the oldest expected response still outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_checker #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int TAB_STEP    = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  tcce_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  tcce_pkg::rsp_t rsp,
  output int             fail_count,
  output int             pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

  // Shadow of the engine state.
  logic [15:0] screen_cells [SCREEN_CELLS];
  logic [4:0]  cur_row;
  logic [6:0]  cur_col;
  logic [7:0]  cur_attr;

  // Responses predicted but not yet seen, oldest first.
  rsp_t cursor_reports [$];
  int   mismatch_total;

  // Blank every cell, home the cursor and go back to white on black.
  function automatic void blank_screen();
    for (int i = 0; i < SCREEN_CELLS; i++) begin
      screen_cells[i] = {DEFAULT_ATTR, CHAR_BLANK};
    end
    cur_row  = '0;
    cur_col  = '0;
    cur_attr = DEFAULT_ATTR;
  endfunction

  // Move to column zero of the next row. On the bottom row the screen moves
  // up one row instead and the new bottom row is blanked in the current
  // attribute. Returns 1 when that scroll happened.
  function automatic logic advance_row();
    cur_col = '0;
    if (int'(cur_row) == SCREEN_ROWS - 1) begin
      for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++) begin
        screen_cells[i] = screen_cells[i + SCREEN_COLS];
      end
      for (int x = 0; x < SCREEN_COLS; x++) begin
        screen_cells[(SCREEN_ROWS - 1) * SCREEN_COLS + x] = {cur_attr, CHAR_BLANK};
      end
      return 1'b1;
    end
    cur_row = cur_row + 1'b1;
    return 1'b0;
  endfunction

  // Apply one request to the shadow state and return the response it causes.
  function automatic rsp_t apply_console_request(input req_t r);
    rsp_t result;
    int   next_col;
    result = '0;
    case (r.req_type)
      REQ_PUT_CHAR: begin
        if (r.char_code == CHAR_NEWLINE) begin
          result.scrolled = advance_row();
        end else if (r.char_code == CHAR_TAB) begin
          // Tabs only move the cursor; a stop past the line end wraps.
          next_col = (int'(cur_col) / TAB_STEP + 1) * TAB_STEP;
          if (next_col >= SCREEN_COLS) begin
            result.scrolled = advance_row();
          end else begin
            cur_col = 7'(next_col);
          end
        end else begin
          screen_cells[int'(cur_row) * SCREEN_COLS + int'(cur_col)] = {cur_attr, r.char_code};
          if (int'(cur_col) == SCREEN_COLS - 1) begin
            result.scrolled = advance_row();
          end else begin
            cur_col = cur_col + 1'b1;
          end
        end
      end
      REQ_BACKSPACE: begin
        // Backspace never leaves the current row.
        if (cur_col != 0) begin
          cur_col = cur_col - 1'b1;
          screen_cells[int'(cur_row) * SCREEN_COLS + int'(cur_col)] = {cur_attr, CHAR_BLANK};
        end
      end
      REQ_CLEAR: begin
        blank_screen();
      end
      REQ_SET_COLOR: begin
        cur_attr = r.color_value;
      end
      REQ_READ_CELL: begin
        // Indexes past the last cell read as zero.
        if (int'(r.cell_index) < SCREEN_CELLS) begin
          result.cell_data = screen_cells[r.cell_index];
        end
      end
      default: begin
      end
    endcase
    result.cursor_row = cur_row;
    result.cursor_col = cur_col;
    return result;
  endfunction

  // Compare one field; count and report a mismatch.
  task automatic compare_field(input string field_name, input logic [15:0] expected_value,
                               input logic [15:0] actual_value);
    if (actual_value !== expected_value) begin
      mismatch_total++;
      $error("%s: expected 0x%0h, actual 0x%0h", field_name, expected_value, actual_value);
    end
  endtask

  // Predict on request transfers, compare on response transfers.
  always @(posedge clk) begin
    rsp_t wanted;
    if (rst) begin
      blank_screen();
      cursor_reports.delete();
      mismatch_total = 0;
    end else begin
      if (req_valid && req_ready) begin
        cursor_reports.push_back(apply_console_request(req));
      end
      if (rsp_valid && rsp_ready) begin
        if (cursor_reports.size() == 0) begin
          mismatch_total++;
          $error("response transfer with no request outstanding: 0x%0h", rsp);
        end else begin
          wanted = cursor_reports.pop_front();
          compare_field("cursor_row", 16'(wanted.cursor_row), 16'(rsp.cursor_row));
          compare_field("cursor_col", 16'(wanted.cursor_col), 16'(rsp.cursor_col));
          compare_field("cell_data", wanted.cell_data, rsp.cell_data);
          compare_field("scrolled", 16'(wanted.scrolled), 16'(rsp.scrolled));
        end
      end
    end
    fail_count    <= mismatch_total;
    pending_count <= cursor_reports.size();
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine testbench
// Drives requests into the engine with random gaps and back-pressure on the
// response side: a short directed opening over the field extremes and
// corner cases, then bursts of text, tabs, newlines, backspaces, readbacks
// and noise. The checker beside the engine predicts and compares; this
// module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  // Highest request code the field can carry; codes above read cell are unused.
  localparam logic [2:0] REQ_CODE_LAST = 3'd7;
  localparam int RANDOM_ITEMS   = 750;
  // Gaps and stalls stop for the last tenth of the random part.
  localparam int CALM_AFTER     = RANDOM_ITEMS * 9 / 10;
  // The limit allows several full screen walks.
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int DRAIN_CYCLES   = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int pending_count;
  int counted_items = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  logic calm = 1'b0;

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  text_console_cursor_engine dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  text_console_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Response back-pressure: rsp_ready is dropped for random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      hold_left <= $urandom_range(0, 9);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL text_console_cursor_engine");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // A request of the given kind with every other field random.
  function automatic req_t random_fill(input logic [2:0] kind);
    req_t r;
    r.req_type    = kind;
    r.char_code   = 8'($urandom);
    r.color_value = 8'($urandom);
    r.cell_index  = 11'($urandom);
    return r;
  endfunction

  // Present one request, maybe after an idle burst, and wait for its transfer.
  task automatic issue(input req_t item);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    if (item.req_type <= REQ_READ_CELL) begin
      counted_items++;
    end
    calm = counted_items >= CALM_AFTER;
  endtask

  task automatic put_char(input logic [7:0] code);
    req_t item;
    item = random_fill(REQ_PUT_CHAR);
    item.char_code = code;
    issue(item);
  endtask

  task automatic read_cell(input int index);
    req_t item;
    item = random_fill(REQ_READ_CELL);
    item.cell_index = 11'(index);
    issue(item);
  endtask

  task automatic set_color(input logic [7:0] attr);
    req_t item;
    item = random_fill(REQ_SET_COLOR);
    item.color_value = attr;
    issue(item);
  endtask

  // Stimulus and verdict.
  initial begin
    int   roll;
    int   run_len;
    req_t item;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Blank screen after reset, the last cell, and reads past the end.
    read_cell(0);
    read_cell(SCREEN_CELLS - 1);
    read_cell(SCREEN_CELLS);
    read_cell(2 ** $bits(item.cell_index) - 1);
    // Backspace at column zero does nothing.
    issue(random_fill(REQ_BACKSPACE));
    // Extreme attribute and character bytes, a tab, then a backspace.
    set_color(8'hFF);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CHAR_TAB);
    issue(random_fill(REQ_BACKSPACE));
    read_cell(0);
    read_cell(1);
    // Unused request codes leave everything alone.
    for (int code = REQ_READ_CELL + 1; code <= REQ_CODE_LAST; code++) begin
      issue(random_fill(3'(code)));
    end
    put_char(CHAR_NEWLINE);
    set_color(8'h00);
    put_char(8'h41);
    read_cell(SCREEN_COLS);
    // Clear restores the default attribute.
    issue(random_fill(REQ_CLEAR));
    put_char(8'h7E);
    read_cell(0);

    // Random bursts of well-formed activity with some noise mixed in.
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        // A run of text, mostly printable.
        run_len = $urandom_range(1, 60);
        repeat (run_len) begin
          if ($urandom_range(0, 9) == 0) begin
            put_char(8'($urandom));
          end else begin
            put_char(8'($urandom_range(32, 126)));
          end
        end
      end else if (roll < 42) begin
        run_len = $urandom_range(1, 24);
        repeat (run_len) put_char(CHAR_TAB);
      end else if (roll < 57) begin
        run_len = $urandom_range(1, 10);
        repeat (run_len) put_char(CHAR_NEWLINE);
      end else if (roll < 67) begin
        run_len = $urandom_range(1, 12);
        repeat (run_len) issue(random_fill(REQ_BACKSPACE));
      end else if (roll < 82) begin
        // Readback, half of it from the bottom rows where the cursor tends to be.
        run_len = $urandom_range(1, 8);
        repeat (run_len) begin
          case ($urandom_range(0, 3))
            0: read_cell(int'(11'($urandom)));
            1, 2: read_cell($urandom_range(SCREEN_CELLS - 3 * SCREEN_COLS, SCREEN_CELLS - 1));
            default: read_cell($urandom_range(0, 2 * SCREEN_COLS - 1));
          endcase
        end
      end else if (roll < 88) begin
        set_color(8'($urandom));
      end else if (roll < 98) begin
        run_len = $urandom_range(1, 4);
        repeat (run_len) issue(random_fill(3'($urandom_range(0, REQ_CODE_LAST))));
      end else begin
        issue(random_fill(REQ_CLEAR));
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS text_console_cursor_engine");
    end else begin
      $display("FAIL text_console_cursor_engine");
    end
    $finish;
  end

endmodule

`default_nettype wire
